[rtl/core/boolean_circuit_evaluator_assert.svh]
// assertion macros for the boolean circuit evaluator
// used by the top level only; no other dependencies
`ifndef BOOLEAN_CIRCUIT_EVALUATOR_ASSERT_SVH
`define BOOLEAN_CIRCUIT_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// condition must never be seen out of reset
`define BCE_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("bce: forbidden condition seen");
// same-cycle implication
`define BCE_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bce: implication failed");
// next-cycle implication
`define BCE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bce: next-cycle implication failed");
`else
`define BCE_ASSERT_NEVER(lbl, ck, rn, cond)
`define BCE_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define BCE_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/core/bce_pkg.sv]
// shared types and constants for the boolean circuit evaluator
// no dependencies; imported by every module of the block
package bce_pkg;

    // wire store geometry
    localparam int WIRE_AW = 20;
    localparam int WIRES   = 1 << WIRE_AW;

    // position counter width
    localparam int POS_W = 20;

    // decoupling queue geometry
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // gate kind codes as they arrive
    localparam logic [2:0] KIND_GEN_IN  = 3'd0;
    localparam logic [2:0] KIND_EVL_IN  = 3'd1;
    localparam logic [2:0] KIND_LOGIC   = 3'd2;
    localparam logic [2:0] KIND_GEN_OUT = 3'd3;
    localparam logic [2:0] KIND_EVL_OUT = 3'd4;

    // party tags on results
    localparam logic PARTY_GEN = 1'b0;
    localparam logic PARTY_EVL = 1'b1;

    // gate class after decode
    typedef enum logic [1:0] {
        CLS_INPUT,
        CLS_LOGIC,
        CLS_GEN_OUT,
        CLS_EVL_OUT
    } gate_class_t;

    // decoded gate as carried through the queue
    typedef struct packed {
        gate_class_t          cls;
        logic                 input_bit;
        logic [3:0]           truth_table;
        logic                 use_second;
        logic [WIRE_AW-1:0]   src0;
        logic [WIRE_AW-1:0]   src1;
        logic [WIRE_AW-1:0]   dest;
    } gate_op_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/core/boolean_circuit_evaluator.sv]
// boolean circuit evaluator top level; uses bce_front, bce_queue, bce_back
// and bce_pkg, assertions from boolean_circuit_evaluator_assert.svh
//
// one decoded gate arrives per request on the gate channel (gate_valid /
// gate_stall); input gates write input_bit to dest_wire, logic and output
// gates look up their truth table with the source wires as index and write
// the result. output gates also send a request on the result channel
// (result_valid / result_stall) with out_bit, out_party and out_position.
// throughput is one gate per cycle unless result_stall holds an output gate:
// the single-bit wire store is read twice and written once each cycle, with
// the retiring gate forwarded to the next one. an accepted gate passes the
// front register, the queue, the store read at issue and evaluation into the result register.
// while result_stall is high the result is held; gates without a result keep
// flowing, and an output gate waits in the evaluate stage, after which the
// four-entry queue fills and gate_stall rises.
// reset clears the pipeline, the queue and both position counters; the wire
// store is not cleared, so a wire must be written before it is read.
`include "boolean_circuit_evaluator_assert.svh"
module boolean_circuit_evaluator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        gate_valid,
    output logic                        gate_stall,
    input  logic [2:0]                  kind,
    input  logic                        input_bit,
    input  logic [3:0]                  truth_table,
    input  logic [1:0]                  arity,
    input  logic [bce_pkg::WIRE_AW-1:0] first_source,
    input  logic [bce_pkg::WIRE_AW-1:0] second_source,
    input  logic [bce_pkg::WIRE_AW-1:0] dest_wire,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        out_bit,
    output logic                        out_party,
    output logic [bce_pkg::POS_W-1:0]   out_position
);
    import bce_pkg::*;

    logic          fr_valid;
    gate_op_t      fr_op;
    queue_status_t q_status;
    gate_op_t      head_op;
    logic          q_pop;

    // decode
    bce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .gate_valid    (gate_valid),
        .gate_stall    (gate_stall),
        .kind          (kind),
        .input_bit     (input_bit),
        .truth_table   (truth_table),
        .arity         (arity),
        .first_source  (first_source),
        .second_source (second_source),
        .dest_wire     (dest_wire),
        .q_status      (q_status),
        .fr_valid      (fr_valid),
        .fr_op         (fr_op)
    );

    // decoupling queue
    bce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_op    (fr_op),
        .pop        (q_pop),
        .q_status   (q_status),
        .head_op    (head_op)
    );

    // evaluation
    bce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_op      (head_op),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_bit      (out_bit),
        .out_party    (out_party),
        .out_position (out_position)
    );

    // queue flags never contradict each other
    `BCE_ASSERT_NEVER(a_queue_flags, clk, rst_n, q_status.full && q_status.empty)
    // back end never takes from an empty queue
    `BCE_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, q_pop, !q_status.empty)
    // a decoded gate blocked by a full queue is kept
    `BCE_ASSERT_NEXT(a_front_holds, clk, rst_n, fr_valid && q_status.full, fr_valid)

endmodule

[rtl/core/bce_front.sv]
// front end: takes gate requests, decodes kind and arity, feeds the queue
// depends on bce_pkg
module bce_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        gate_valid,
    output logic                        gate_stall,
    input  logic [2:0]                  kind,
    input  logic                        input_bit,
    input  logic [3:0]                  truth_table,
    input  logic [1:0]                  arity,
    input  logic [bce_pkg::WIRE_AW-1:0] first_source,
    input  logic [bce_pkg::WIRE_AW-1:0] second_source,
    input  logic [bce_pkg::WIRE_AW-1:0] dest_wire,
    input  bce_pkg::queue_status_t      q_status,
    output logic                        fr_valid,
    output bce_pkg::gate_op_t           fr_op
);
    import bce_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        load;
    gate_op_t    op_reg;
    gate_op_t    op_next;
    gate_class_t cls;

    // kind decode; unused codes behave as plain logic gates
    always_comb
    begin
        unique case (kind)
            KIND_GEN_IN,
            KIND_EVL_IN:  cls = CLS_INPUT;
            KIND_GEN_OUT: cls = CLS_GEN_OUT;
            KIND_EVL_OUT: cls = CLS_EVL_OUT;
            default:      cls = CLS_LOGIC;
        endcase
    end

    // pack the decoded request; arity three counts as two, zero as one
    always_comb
    begin
        op_next.cls         = cls;
        op_next.input_bit   = input_bit;
        op_next.truth_table = truth_table;
        op_next.use_second  = arity[1];
        op_next.src0        = first_source;
        op_next.src1        = second_source;
        op_next.dest        = dest_wire;
    end

    // holding register moves on whenever the queue has room
    always_comb
    begin
        gate_stall = valid_reg && q_status.full;
        load       = gate_valid && !gate_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!q_status.full)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg <= op_next;
        end
    end

    assign fr_valid = valid_reg;
    assign fr_op    = op_reg;

endmodule

[rtl/core/bce_queue.sv]
// short fifo that decouples the decoder from the evaluation pipeline
// depends on bce_pkg
module bce_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  bce_pkg::gate_op_t      push_op,
    input  logic                   pop,
    output bce_pkg::queue_status_t q_status,
    output bce_pkg::gate_op_t      head_op
);
    import bce_pkg::*;

    gate_op_t            entry_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;

    // status flags
    always_comb
    begin
        q_status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
        q_status.empty = (count_reg == '0);
        push           = push_valid && !q_status.full;
    end

    // occupancy
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op = entry_mem[rd_ptr_reg];

endmodule

[rtl/core/bce_back.sv]
// back end: wire store, two-stage evaluation with forwarding, result register
// depends on bce_pkg
module bce_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bce_pkg::queue_status_t      q_status,
    input  bce_pkg::gate_op_t           head_op,
    output logic                        pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        out_bit,
    output logic                        out_party,
    output logic [bce_pkg::POS_W-1:0]   out_position
);
    import bce_pkg::*;

    // one bit per wire, read twice and written once per cycle
    logic wire_mem [WIRES];

    logic             ex_valid_reg;
    logic             ex_valid_next;
    gate_op_t         ex_op_reg;
    logic             rd0_reg;
    logic             rd1_reg;
    logic             fwd0_reg;
    logic             fwd1_reg;
    logic             fwd_bit_reg;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             out_bit_reg;
    logic             out_party_reg;
    logic [POS_W-1:0] out_position_reg;
    logic [POS_W-1:0] gen_cnt_reg;
    logic [POS_W-1:0] gen_cnt_next;
    logic [POS_W-1:0] evl_cnt_reg;
    logic [POS_W-1:0] evl_cnt_next;

    logic             out_free;
    logic             ex_is_out;
    logic             ex_fire;
    logic             issue;
    logic             bit0;
    logic             bit1;
    logic [1:0]       tix;
    logic             ex_res;

    // pipeline advance
    always_comb
    begin
        out_free  = !result_valid_reg || !result_stall;
        ex_is_out = (ex_op_reg.cls == CLS_GEN_OUT) || (ex_op_reg.cls == CLS_EVL_OUT);
        ex_fire   = ex_valid_reg && (!ex_is_out || out_free);
        issue     = !q_status.empty && (!ex_valid_reg || ex_fire);
        pop       = issue;
    end

    // evaluate the gate in the execute stage
    always_comb
    begin
        bit0   = fwd0_reg ? fwd_bit_reg : rd0_reg;
        bit1   = fwd1_reg ? fwd_bit_reg : rd1_reg;
        tix    = {ex_op_reg.use_second & bit1, bit0};
        ex_res = (ex_op_reg.cls == CLS_INPUT) ? ex_op_reg.input_bit
                                              : ex_op_reg.truth_table[tix];
    end

    // next values of control state
    always_comb
    begin
        if (issue)
        begin
            ex_valid_next = 1'b1;
        end
        else if (ex_fire)
        begin
            ex_valid_next = 1'b0;
        end
        else
        begin
            ex_valid_next = ex_valid_reg;
        end

        if (ex_fire && ex_is_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end

        gen_cnt_next = gen_cnt_reg;
        evl_cnt_next = evl_cnt_reg;
        if (ex_fire && (ex_op_reg.cls == CLS_GEN_OUT))
        begin
            gen_cnt_next = gen_cnt_reg + 1'b1;
        end
        if (ex_fire && (ex_op_reg.cls == CLS_EVL_OUT))
        begin
            evl_cnt_next = evl_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            gen_cnt_reg      <= '0;
            evl_cnt_reg      <= '0;
        end
        else
        begin
            ex_valid_reg     <= ex_valid_next;
            result_valid_reg <= result_valid_next;
            gen_cnt_reg      <= gen_cnt_next;
            evl_cnt_reg      <= evl_cnt_next;
        end
    end

    // wire store: write from execute, registered reads at issue
    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            wire_mem[ex_op_reg.dest] <= ex_res;
        end
        if (issue)
        begin
            rd0_reg <= wire_mem[head_op.src0];
            rd1_reg <= wire_mem[head_op.src1];
        end
    end

    // issue register and forwarding from the gate retiring this cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ex_op_reg   <= head_op;
            fwd0_reg    <= ex_valid_reg && (head_op.src0 == ex_op_reg.dest);
            fwd1_reg    <= ex_valid_reg && (head_op.src1 == ex_op_reg.dest);
            fwd_bit_reg <= ex_res;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ex_fire && ex_is_out)
        begin
            out_bit_reg <= ex_res;
            if (ex_op_reg.cls == CLS_GEN_OUT)
            begin
                out_party_reg    <= PARTY_GEN;
                out_position_reg <= gen_cnt_reg;
            end
            else
            begin
                out_party_reg    <= PARTY_EVL;
                out_position_reg <= evl_cnt_reg;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign out_bit      = out_bit_reg;
    assign out_party    = out_party_reg;
    assign out_position = out_position_reg;

endmodule
